/* rtl/opvf_pkg.sv */
// Shared constants, command codes and types of the on-path vertex finder.
`timescale 1ns / 1ps

package opvf_pkg;

	// Built graph size; the adjacency row and the result mask are this wide.
	localparam int MAX_VERTICES = 32;
	localparam int ROW_W        = MAX_VERTICES;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	// Field widths of the stream items.
	localparam int CMD_W        = 2;
	localparam int IN_TDATA_W   = 48;
	localparam int OUT_TDATA_W  = 40;
	localparam int VCOUNT_W     = 6;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;

	// Command codes carried in s_tuser.
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	// Register index of vertex_count.
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// Forward and backward reachability sets of one query.
	typedef struct packed {
		logic [ROW_W-1:0] fwd;
		logic [ROW_W-1:0] bwd;
	} reach_sets_t;

endpackage

/* rtl/opvf_closure_unit.sv */
// Shared closure step: folds one adjacency row into both reachability sets.
`timescale 1ns / 1ps

module opvf_closure_unit (
	input  logic [opvf_pkg::ROW_W-1:0]  row,
	input  logic [opvf_pkg::VIDX_W-1:0] vertex,
	input  logic [opvf_pkg::ROW_W-1:0]  valid_mask,
	input  opvf_pkg::reach_sets_t       cur,
	output opvf_pkg::reach_sets_t       nxt,
	output logic                        grew
);

	logic [opvf_pkg::ROW_W-1:0] row_in_use;
	logic [opvf_pkg::ROW_W-1:0] vertex_bit;

	assign row_in_use = row & valid_mask;
	assign vertex_bit = opvf_pkg::ROW_W'(1) << vertex;

	always_comb begin
		nxt = cur;
		// A reached vertex reaches all its neighbors.
		if (cur.fwd[vertex]) begin
			nxt.fwd = cur.fwd | row_in_use;
		end
		// A vertex with an edge into the backward set can reach the destination.
		if (!cur.bwd[vertex] && ((row_in_use & cur.bwd) != '0)) begin
			nxt.bwd = cur.bwd | vertex_bit;
		end
	end

	assign grew = (nxt.fwd != cur.fwd) || (nxt.bwd != cur.bwd);

endmodule

/* rtl/on_path_vertex_finder.sv */
// Top level of the on-path vertex finder: row store, query sequencer and ports.
// A clear or a row write is accepted back to back.
// A query with an endpoint out of range goes straight to the done state and then
// presents its result. An in-range query runs S sweeps over the rows in use (n =
// vertices in use, S from 1 to n until neither set grows), then a bit-serial
// population count, then loads the output register; input stays closed.
// Reset is asynchronous: vertex_count returns to 32, all rows read as empty.
`timescale 1ns / 1ps

module on_path_vertex_finder (
	input  logic                                clk,
	input  logic                                arst_n,

	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata, lowest bit up: row_vertex[4:0], row_mask[36:5], src_vertex[41:37],
	// dst_vertex[46:42], zero fill [47].
	input  logic [opvf_pkg::IN_TDATA_W-1:0]     s_tdata,
	// s_tuser: cmd[1:0].
	input  logic [opvf_pkg::CMD_W-1:0]          s_tuser,

	// Result stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata, lowest bit up: on_path_mask[31:0], on_path_count[37:32],
	// zero fill [39:38].
	output logic [opvf_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// m_tuser: query_in_range[0].
	output logic                                m_tuser,

	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [opvf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [opvf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [opvf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_COUNT,
		ST_DONE
	} state_t;

	// Unpacked input fields.
	logic [opvf_pkg::VIDX_W-1:0] row_vertex;
	logic [opvf_pkg::ROW_W-1:0]  row_mask;
	logic [opvf_pkg::VIDX_W-1:0] src_vertex;
	logic [opvf_pkg::VIDX_W-1:0] dst_vertex;

	assign row_vertex = s_tdata[4:0];
	assign row_mask   = s_tdata[36:5];
	assign src_vertex = s_tdata[41:37];
	assign dst_vertex = s_tdata[46:42];

	// Configuration register. pready is tied high, so a write lands on the
	// access cycle itself.
	logic [opvf_pkg::VCOUNT_W-1:0] vertex_count_q;
	logic                          cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= opvf_pkg::VCOUNT_W'(opvf_pkg::MAX_VERTICES);
		end else if (cfg_write && (paddr[2] == opvf_pkg::REG_VERTEX_COUNT)) begin
			vertex_count_q <= pwdata[opvf_pkg::VCOUNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == opvf_pkg::REG_VERTEX_COUNT) ?
		opvf_pkg::APB_DATA_W'(vertex_count_q) : '0;

	// Vertices in use: the configured count, limited to the built size.
	logic [opvf_pkg::CNT_W-1:0] n_in_use;
	logic                       query_ok;

	assign n_in_use = (opvf_pkg::CNT_W'(vertex_count_q) >
		opvf_pkg::CNT_W'(opvf_pkg::MAX_VERTICES)) ?
		opvf_pkg::CNT_W'(opvf_pkg::MAX_VERTICES) : opvf_pkg::CNT_W'(vertex_count_q);
	assign query_ok = (opvf_pkg::CNT_W'(src_vertex) < n_in_use) &&
		(opvf_pkg::CNT_W'(dst_vertex) < n_in_use);

	// Handshakes.
	state_t state_q;
	logic   in_fire;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// Adjacency store: one row per vertex, one write port and one registered
	// read port. A clear drops every row valid flag at once, and a row
	// whose flag is down reads as all zero, so no clearing pass is needed.
	logic [opvf_pkg::ROW_W-1:0]        adj_mem [opvf_pkg::MAX_VERTICES];
	logic [opvf_pkg::MAX_VERTICES-1:0] row_vld_q;
	logic [opvf_pkg::ROW_W-1:0]        rd_raw_q;
	logic                              rd_vld_q;
	logic                              row_wr;
	logic                              rd_en;
	logic [opvf_pkg::VIDX_W-1:0]       rd_addr;

	assign row_wr = in_fire && (s_tuser == opvf_pkg::CMD_WRITE);

	always_ff @(posedge clk) begin
		if (row_wr) begin
			adj_mem[row_vertex] <= row_mask;
		end
		if (rd_en) begin
			rd_raw_q <= adj_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (in_fire && (s_tuser == opvf_pkg::CMD_CLEAR)) begin
				row_vld_q <= '0;
			end else if (row_wr) begin
				row_vld_q[row_vertex] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// Sequencer registers.
	logic [opvf_pkg::CNT_W-1:0]  n_q;          // vertices in use for this query
	logic [opvf_pkg::ROW_W-1:0]  valid_mask_q; // bits below n_q
	logic [opvf_pkg::CNT_W-1:0]  issue_q;      // next vertex whose row is read
	logic                        proc_vld_s1;  // a row read is returning
	logic [opvf_pkg::VIDX_W-1:0] proc_v_s1;    // vertex of the returning row
	logic                        grew_q;       // some set grew during this sweep
	opvf_pkg::reach_sets_t       sets_q;
	logic [opvf_pkg::ROW_W-1:0]  shift_q;      // intersection, shifted out for the count
	logic [opvf_pkg::ROW_W-1:0]  res_mask_q;
	logic [opvf_pkg::CNT_W-1:0]  res_cnt_q;
	logic                        res_ok_q;

	logic [opvf_pkg::ROW_W-1:0]  rd_row;
	logic [opvf_pkg::ROW_W-1:0]  n_mask;
	opvf_pkg::reach_sets_t       sets_nxt;
	logic                        unit_grew;
	logic                        issue_more;

	assign rd_row     = rd_vld_q ? rd_raw_q : '0;
	assign issue_more = (issue_q < n_q);
	assign rd_en      = (state_q == ST_SWEEP) && issue_more;
	assign rd_addr    = issue_q[opvf_pkg::VIDX_W-1:0];

	always_comb begin
		for (int i = 0; i < opvf_pkg::ROW_W; i++) begin
			n_mask[i] = (opvf_pkg::CNT_W'(i) < n_in_use);
		end
	end

	// The one shared unit: every returning row passes through it.
	opvf_closure_unit u_closure (
		.row        (rd_row),
		.vertex     (proc_v_s1),
		.valid_mask (valid_mask_q),
		.cur        (sets_q),
		.nxt        (sets_nxt),
		.grew       (unit_grew)
	);

	// Query sequencer. Each sweep reads every row in use once, feeding the
	// returning row to the closure unit while the next read is in flight.
	// Sweeps repeat until neither set grows; that fixed point is the full
	// forward and backward closure whatever the order of the rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			proc_vld_s1 <= 1'b0;
			issue_q     <= '0;
			grew_q      <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			// The result register fills as a finished query leaves ST_DONE and
			// empties when the receiver takes it.
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (s_tuser == opvf_pkg::CMD_QUERY)) begin
						n_q          <= n_in_use;
						valid_mask_q <= n_mask;
						sets_q.fwd   <= opvf_pkg::ROW_W'(1) << src_vertex;
						sets_q.bwd   <= opvf_pkg::ROW_W'(1) << dst_vertex;
						issue_q      <= '0;
						grew_q       <= 1'b0;
						proc_vld_s1  <= 1'b0;
						res_ok_q     <= query_ok;
						res_mask_q   <= '0;
						res_cnt_q    <= '0;
						// An endpoint out of range reports an empty mask at once.
						state_q      <= query_ok ? ST_SWEEP : ST_DONE;
					end
				end
				ST_SWEEP: begin
					proc_vld_s1 <= issue_more;
					proc_v_s1   <= rd_addr;
					if (issue_more) begin
						issue_q <= issue_q + opvf_pkg::CNT_W'(1);
					end
					if (proc_vld_s1) begin
						sets_q <= sets_nxt;
						grew_q <= grew_q || unit_grew;
					end else if (!issue_more) begin
						// Sweep finished: repeat it or start the count.
						if (grew_q) begin
							issue_q <= '0;
							grew_q  <= 1'b0;
						end else begin
							res_mask_q <= sets_q.fwd & sets_q.bwd;
							shift_q    <= sets_q.fwd & sets_q.bwd;
							res_cnt_q  <= '0;
							state_q    <= ST_COUNT;
						end
					end
				end
				ST_COUNT: begin
					// One bit a cycle; stops as soon as no set bit remains.
					if (shift_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						res_cnt_q <= res_cnt_q + opvf_pkg::CNT_W'(shift_q[0]);
						shift_q   <= shift_q >> 1;
					end
				end
				ST_DONE: begin
					// Waits here only while an earlier result is still unread.
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: loaded from the result registers as the result goes out.
	logic [opvf_pkg::ROW_W-1:0] out_mask_q;
	logic [opvf_pkg::CNT_W-1:0] out_cnt_q;
	logic                       out_ok_q;

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_mask_q <= res_mask_q;
			out_cnt_q  <= res_cnt_q;
			out_ok_q   <= res_ok_q;
		end
	end

	assign m_tdata = {2'b00, out_cnt_q, out_mask_q};
	assign m_tuser = out_ok_q;

endmodule

/* rtl/opvf_checker.sv */
// Port-level assertions for the on-path vertex finder, bound to the top level.
`timescale 1ns / 1ps

module opvf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [opvf_pkg::CMD_W-1:0]       s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [opvf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tuser
);

	// A query keeps the input side closed for at least the next cycle.
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == opvf_pkg::CMD_QUERY)) |=> !s_tready)
		else $error("input accepted right after a query");

	// The count always matches the mask it goes with.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[37:32] == 6'($countones(m_tdata[31:0]))))
		else $error("on_path_count does not match on_path_mask");

	// An out-of-range query carries an empty mask and a zero count.
	a_out_of_range_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("out-of-range result is not empty");

	// A stalled result holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

endmodule

bind on_path_vertex_finder opvf_checker u_opvf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
